// ----- rtl/fqmc_pkg.sv -----
// Shared types and constants for the FIFO queue with match count.
`timescale 1ns / 1ps

package fqmc_pkg;

  // Field widths fixed by the item format
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;
  localparam int DATA_W = 32;

  // Operation codes carried by an input item
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_COUNT  = 2'd2
  } op_t;

  // Status codes carried by a result item
  typedef enum logic [ST_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

// ----- rtl/fifo_queue_with_match_count.sv -----
// Top level: bounded FIFO queue of signed values with insert, remove and match count.
//
//   channel | direction | fields
//   --------+-----------+---------------------------------------------------------
//   in_     | input     | operation, value
//   out_    | output    | status, match_count, occupancy, head_valid, head_value
//
// Insert and remove pass through the head read and capture steps to the result; a
// count first scans the store, one entry store read per held entry through the single
// read port. One item is in work at a time; the output register holds a
// finished result so a new item is taken while the result waits.
// Reset clears pointers, occupancy and control; the entry store needs no clearing.
// A result stalled at the output holds the sequencer in its last step.
`timescale 1ns / 1ps

module fifo_queue_with_match_count #(
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [fqmc_pkg::OP_W-1:0]              in_operation,
  input  logic signed [fqmc_pkg::DATA_W-1:0]     in_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [fqmc_pkg::ST_W-1:0]              out_status,
  output logic [$clog2(DEPTH+1)-1:0]             out_match_count,
  output logic [$clog2(DEPTH+1)-1:0]             out_occupancy,
  output logic                                   out_head_valid,
  output logic signed [fqmc_pkg::DATA_W-1:0]     out_head_value
);

  import fqmc_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_HEAD = 4'b0100,
    S_CAP  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [AW-1:0]       tail_r, tail_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [DATA_W-1:0]   val_r, val_nxt;
  logic [ST_W-1:0]     status_r, status_nxt;
  logic [AW-1:0]       scan_addr_r, scan_addr_nxt;
  logic [CW-1:0]       scan_left_r, scan_left_nxt;
  logic                cmp_v_r, cmp_v_nxt;
  logic [CW-1:0]       match_r, match_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]     out_status_r, out_status_nxt;
  logic [CW-1:0]       out_match_r, out_match_nxt;
  logic [CW-1:0]       out_occ_r, out_occ_nxt;
  logic                out_hv_r, out_hv_nxt;
  logic [DATA_W-1:0]   out_hval_r, out_hval_nxt;

  logic                ram_we;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [DATA_W-1:0]   ram_rdata;
  logic                accept;
  logic                out_free;
  logic                full;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] slot);
    next_slot = (slot == AW'(DEPTH - 1)) ? '0 : slot + 1'b1;
  endfunction

  // Entry store
  fqmc_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (val_nxt),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign full     = (cnt_r == CW'(DEPTH));

  // Sequence one item: update pointers, scan the store, read the head, load result
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cnt_nxt        = cnt_r;
    val_nxt        = val_r;
    status_nxt     = status_r;
    scan_addr_nxt  = scan_addr_r;
    scan_left_nxt  = scan_left_r;
    cmp_v_nxt      = cmp_v_r;
    match_nxt      = match_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_match_nxt  = out_match_r;
    out_occ_nxt    = out_occ_r;
    out_hv_nxt     = out_hv_r;
    out_hval_nxt   = out_hval_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = head_r;

    // Drop the result once it has been transferred
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // Compare the entry read in the previous cycle
    if (cmp_v_r && (ram_rdata == val_r)) begin
      match_nxt = match_r + 1'b1;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          val_nxt    = in_value;
          status_nxt = ST_DONE;
          match_nxt  = '0;
          cmp_v_nxt  = 1'b0;
          state_nxt  = S_HEAD;
          case (in_operation)
            OP_INSERT: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                ram_we   = 1'b1;
                tail_nxt = next_slot(tail_r);
                cnt_nxt  = cnt_r + 1'b1;
              end
            end
            OP_REMOVE: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                head_nxt = next_slot(head_r);
                cnt_nxt  = cnt_r - 1'b1;
              end
            end
            OP_COUNT: begin
              if (cnt_r != '0) begin
                scan_addr_nxt = head_r;
                scan_left_nxt = cnt_r;
                state_nxt     = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        ram_re        = 1'b1;
        ram_raddr     = scan_addr_r;
        scan_addr_nxt = next_slot(scan_addr_r);
        scan_left_nxt = scan_left_r - 1'b1;
        cmp_v_nxt     = 1'b1;
        if (scan_left_r == CW'(1)) begin
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        ram_re    = 1'b1;
        ram_raddr = head_r;
        cmp_v_nxt = 1'b0;
        state_nxt = S_CAP;
      end
      S_CAP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_match_nxt  = match_r;
          out_occ_nxt    = cnt_r;
          out_hv_nxt     = (cnt_r != '0);
          out_hval_nxt   = (cnt_r != '0) ? ram_rdata : '0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    val_r        <= val_nxt;
    status_r     <= status_nxt;
    scan_addr_r  <= scan_addr_nxt;
    scan_left_r  <= scan_left_nxt;
    match_r      <= match_nxt;
    out_status_r <= out_status_nxt;
    out_match_r  <= out_match_nxt;
    out_occ_r    <= out_occ_nxt;
    out_hv_r     <= out_hv_nxt;
    out_hval_r   <= out_hval_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_match_count = out_match_r;
  assign out_occupancy   = out_occ_r;
  assign out_head_valid  = out_hv_r;
  assign out_head_value  = out_hval_r;

endmodule

// ----- rtl/fqmc_ram.sv -----
// Generic single-clock RAM, one write port and one registered read port.
`timescale 1ns / 1ps

module fqmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on request, register read data on request
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/fqmc_checker.sv -----
// Port-level checks for the FIFO queue with match count, bound to the top level.
`timescale 1ns / 1ps

module fqmc_checker #(
  parameter int DEPTH = 16
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [fqmc_pkg::ST_W-1:0]          out_status,
  input logic [$clog2(DEPTH+1)-1:0]         out_match_count,
  input logic [$clog2(DEPTH+1)-1:0]         out_occupancy,
  input logic                               out_head_valid,
  input logic signed [fqmc_pkg::DATA_W-1:0] out_head_value
);

  import fqmc_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_occupancy) && $stable(out_head_value))
    else $error("stalled result changed");

  // Take one item at a time: a transfer closes the input for the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

  // Head flag follows occupancy, and an empty queue shows a zero head
  a_head_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_head_valid == (out_occupancy != '0)) &&
      (out_head_valid || (out_head_value == '0)))
    else $error("head flag or value inconsistent with occupancy");

  // Occupancy and matches stay within the queue
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_occupancy <= CW'(DEPTH)) && (out_match_count <= out_occupancy))
    else $error("occupancy or match count out of range");

  // A failed insert or remove reports no matches
  a_status_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_DONE) |-> out_match_count == '0)
    else $error("match count on a failed operation");

endmodule

bind fifo_queue_with_match_count fqmc_checker #(.DEPTH(DEPTH)) u_fqmc_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench for the bounded FIFO queue with match count.
`timescale 1ns / 1ps

module testbench;
  import fqmc_pkg::*;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 500;
  localparam int TAIL_CYCLES = 4 * DEPTH;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_LIMIT = 50;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    bit                       wait_idle;
  } queue_cmd_t;

  typedef struct {
    logic [ST_W-1:0]          status;
    logic [CNT_W-1:0]         match_count;
    logic [CNT_W-1:0]         occupancy;
    logic                     head_valid;
    logic signed [DATA_W-1:0] head_value;
  } queue_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [OP_W-1:0]          in_operation = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [ST_W-1:0]          out_status;
  logic [CNT_W-1:0]         out_match_count;
  logic [CNT_W-1:0]         out_occupancy;
  logic                     out_head_valid;
  logic signed [DATA_W-1:0] out_head_value;

  fifo_queue_with_match_count #(.DEPTH(DEPTH)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_match_count (out_match_count),
    .out_occupancy   (out_occupancy),
    .out_head_valid  (out_head_valid),
    .out_head_value  (out_head_value)
  );

  queue_cmd_t    pending_cmds[$];
  queue_result_t expected_results[$];
  int            mismatch_count = 0;
  int            cycle_count = 0;

  // Shadow copy of the queue contents
  logic signed [DATA_W-1:0] shadow_slots[DEPTH];
  int unsigned              shadow_head = 0;
  int unsigned              shadow_tail = 0;
  int unsigned              shadow_held = 0;

  // Values reused so that inserts and counts meet each other
  logic signed [DATA_W-1:0] value_pool[8];
  int                       random_issued = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int unsigned wrap_slot(input int unsigned slot);
    return (slot == DEPTH - 1) ? 0 : slot + 1;
  endfunction

  // Apply one operation to the shadow queue and return the result it gives
  function automatic queue_result_t apply_queue_op(input logic [OP_W-1:0] op,
                                                   input logic signed [DATA_W-1:0] value);
    queue_result_t res;
    int unsigned   slot;
    res.status = ST_DONE;
    res.match_count = '0;
    case (op)
      OP_INSERT: begin
        if (shadow_held == DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_slots[shadow_tail] = value;
          shadow_tail = wrap_slot(shadow_tail);
          shadow_held++;
        end
      end
      OP_REMOVE: begin
        if (shadow_held == 0) begin
          res.status = ST_EMPTY;
        end else begin
          shadow_head = wrap_slot(shadow_head);
          shadow_held--;
        end
      end
      OP_COUNT: begin
        slot = shadow_head;
        for (int i = 0; i < shadow_held; i++) begin
          if (shadow_slots[slot] == value) res.match_count++;
          slot = wrap_slot(slot);
        end
      end
      default: begin
      end
    endcase
    res.occupancy = shadow_held[CNT_W-1:0];
    res.head_valid = (shadow_held != 0);
    res.head_value = (shadow_held != 0) ? shadow_slots[shadow_head] : '0;
    return res;
  endfunction

  task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  task automatic queue_cmd(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value,
                           input bit wait_idle = 1'b0);
    queue_cmd_t cmd;
    cmd.op = op;
    cmd.value = value;
    cmd.wait_idle = wait_idle;
    pending_cmds.push_back(cmd);
  endtask

  task automatic queue_random_cmd(input logic [OP_W-1:0] op,
                                  input logic signed [DATA_W-1:0] value);
    // Hold off every so often until the queue has answered everything
    queue_cmd(op, value, (random_issued % 120) == 0);
    random_issued++;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 9) < 7) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // Driver: present pending transfers in bursts separated by gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin : cmd_driver
    queue_cmd_t cmd;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_results.push_back(apply_queue_op(in_operation, in_value));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() == 0 ||
                     (pending_cmds[0].wait_idle && expected_results.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          cmd = pending_cmds.pop_front();
          in_valid <= 1'b1;
          in_operation <= cmd.op;
          in_value <= cmd.value;
          burst_left--;
          if (burst_left <= 0) begin
            if ($urandom_range(0, 3) == 0) begin
              burst_left = $urandom_range(20, 60);
              gap_left = 0;
            end else begin
              burst_left = $urandom_range(1, 8);
              gap_left = $urandom_range(1, 24);
            end
          end
        end
      end
    end
  end

  // Monitor: check each result transfer and drive the stall pattern
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  logic stall_next = 1'b0;

  always @(posedge clk) begin : result_monitor
    queue_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: unexpected result, expected none, actual status %0h",
                   $time, out_status);
      end else begin
        want = expected_results.pop_front();
        check_field("status", DATA_W'(want.status), DATA_W'(out_status));
        check_field("match_count", DATA_W'(want.match_count), DATA_W'(out_match_count));
        check_field("occupancy", DATA_W'(want.occupancy), DATA_W'(out_occupancy));
        check_field("head_valid", DATA_W'(want.head_valid), DATA_W'(out_head_valid));
        check_field("head_value", want.head_value, out_head_value);
      end
    end
    // Switch stall style now and then: none, random, long runs, toggling
    if (mode_left <= 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(50, 200);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
    end else begin
      case (stall_mode)
        0: begin
          stall_next = 1'b0;
          hold_left = $urandom_range(1, 8);
        end
        1: stall_next = 1'($urandom_range(0, 1));
        2: begin
          stall_next = 1'($urandom_range(0, 1));
          hold_left = $urandom_range(1, 20);
        end
        default: begin
          stall_next = ~stall_next;
          hold_left = 1;
        end
      endcase
    end
    out_stall <= stall_next;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic signed [DATA_W-1:0] fill_value;
    int                       run_len;

    // Empty queue: remove, count and the unused code
    queue_cmd(OP_REMOVE, 32'sd0);
    queue_cmd(OP_COUNT, 32'sd0);
    queue_cmd(OP_UNUSED, 32'sh5A5A_5A5A);
    // Extremes, then fill up with one repeated value
    queue_cmd(OP_INSERT, 32'sh7FFF_FFFF);
    queue_cmd(OP_INSERT, 32'sh8000_0000);
    queue_cmd(OP_INSERT, -32'sd1);
    queue_cmd(OP_INSERT, 32'sd0);
    for (int i = 0; i < DEPTH - 4; i++) queue_cmd(OP_INSERT, 32'sd5);
    // Full queue: drop an insert, count and ignore
    queue_cmd(OP_INSERT, 32'sd9);
    queue_cmd(OP_COUNT, 32'sd5);
    queue_cmd(OP_COUNT, 32'sh8000_0000);
    queue_cmd(OP_UNUSED, 32'shA5A5_A5A5);
    queue_cmd(OP_REMOVE, 32'sd0);
    queue_cmd(OP_COUNT, -32'sd1);

    value_pool[0] = 32'sh7FFF_FFFF;
    value_pool[1] = 32'sh8000_0000;
    value_pool[2] = 32'sd0;
    value_pool[3] = -32'sd1;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

    // Random sequences of well-formed runs with some noise
    while (random_issued < RANDOM_ITEMS) begin
      if ($urandom_range(0, 15) == 0) value_pool[$urandom_range(4, 7)] = $urandom;
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          run_len = $urandom_range(1, DEPTH + 2);
          for (int i = 0; i < run_len; i++) queue_random_cmd(OP_INSERT, pick_value());
        end
        3, 4: begin
          run_len = $urandom_range(1, DEPTH + 2);
          for (int i = 0; i < run_len; i++) queue_random_cmd(OP_REMOVE, $urandom);
        end
        5, 6: begin
          run_len = $urandom_range(1, 4);
          for (int i = 0; i < run_len; i++) queue_random_cmd(OP_COUNT, pick_value());
        end
        7: begin
          // Any code, the unused one included
          run_len = $urandom_range(1, 8);
          for (int i = 0; i < run_len; i++)
            queue_random_cmd(OP_W'($urandom_range(0, 3)), $urandom);
        end
        8: begin
          run_len = $urandom_range(1, 10);
          for (int i = 0; i < run_len; i++)
            queue_random_cmd(OP_W'($urandom_range(0, 2)), pick_value());
        end
        default: begin
          // Drain, fill with one value and count a full match
          fill_value = pick_value();
          for (int i = 0; i <= DEPTH; i++) queue_random_cmd(OP_REMOVE, $urandom);
          for (int i = 0; i < DEPTH; i++) queue_random_cmd(OP_INSERT, fill_value);
          queue_random_cmd(OP_COUNT, fill_value);
          queue_random_cmd(OP_INSERT, $urandom);
          queue_random_cmd(OP_COUNT, $urandom);
        end
      endcase
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every transfer to be taken and answered
    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/fqmc_pkg.sv
rtl/fqmc_ram.sv
rtl/fifo_queue_with_match_count.sv
rtl/fqmc_checker.sv
tb/testbench.sv
